>>> src/scalar_kalman_filter_core_macros.svh
// Assertion macros used by the checker of the scalar Kalman filter core.
`ifndef SCALAR_KALMAN_FILTER_CORE_MACROS_SVH
`define SCALAR_KALMAN_FILTER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SKF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scalar kalman filter core check failed");

// Consequent must hold in the cycle after the antecedent.
`define SKF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scalar kalman filter core check failed");

`endif

>>> src/skf_pkg.sv
// Shared types, codes and constants of the scalar Kalman filter core.
`default_nettype none

package skf_pkg;

    localparam int DEFAULT_FRAC_BITS = 16;
    localparam int DIV_STEPS = 32;
    localparam int CFG_ADDR_W = 2;

    typedef logic [CFG_ADDR_W-1:0] skf_reg_idx_t;

    localparam skf_reg_idx_t REG_PROCESS_NOISE     = 2'd0;
    localparam skf_reg_idx_t REG_MEASUREMENT_NOISE = 2'd1;
    localparam skf_reg_idx_t REG_STATE_GAIN        = 2'd2;
    localparam skf_reg_idx_t REG_OBSERVE_GAIN      = 2'd3;

    typedef logic [3:0] skf_op_t;

    localparam skf_op_t OP_X0  = 4'd0;  // x0 = F*S
    localparam skf_op_t OP_FC  = 4'd1;  // F*C
    localparam skf_op_t OP_P0  = 4'd2;  // p0 = F*C*F + Q
    localparam skf_op_t OP_HP  = 4'd3;  // H*p0
    localparam skf_op_t OP_DEN = 4'd4;  // H*p0*H + R
    localparam skf_op_t OP_INN = 4'd5;  // V - H*x0
    localparam skf_op_t OP_EST = 4'd6;  // S = x0 + K*innov
    localparam skf_op_t OP_KH  = 4'd7;  // 1 - K*H
    localparam skf_op_t OP_COV = 4'd8;  // C = (1-K*H)*p0

    typedef struct packed {
        logic    in_load;
        logic    init_load;
        logic    issue;
        skf_op_t op;
        logic    div_start;
        logic    out_load;
        logic    out_flag;
    } skf_cmd_t;

    typedef struct packed {
        logic mul_busy;
        logic div_busy;
    } skf_status_t;

endpackage

`default_nettype wire

>>> src/skf_div.sv
// Iterative signed fixed-point divider for the Kalman gain, one quotient bit per cycle.
`default_nettype none

module skf_div #(
    parameter int FRAC_BITS = skf_pkg::DEFAULT_FRAC_BITS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] num,
    input  wire logic signed [31:0] den,
    output logic                    busy,
    output logic                    zero,
    output logic signed [31:0]      quot
);
    import skf_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic                    busy_reg;
    logic                    zero_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    neg_reg;
    logic [31:0]             ud_reg;
    logic [31:0]             rem_reg;
    logic [31:0]             shf_reg;
    logic signed [31:0]      quot_reg;

    logic [31:0]             num_abs;
    logic [31:0]             den_abs;
    logic [32+FRAC_BITS-1:0] dividend;
    logic [31:0]             high_part;
    logic                    start_ovf;
    logic [32:0]             trial;
    logic                    ge;
    logic [31:0]             rem_next;

    assign num_abs   = num[31] ? 32'(-num) : 32'(num);
    assign den_abs   = den[31] ? 32'(-den) : 32'(den);
    assign dividend  = {num_abs, {FRAC_BITS{1'b0}}};
    assign high_part = 32'(dividend[32+FRAC_BITS-1:32]);
    assign start_ovf = (high_part >= den_abs);

    assign trial    = {rem_reg, shf_reg[31]};
    assign ge       = (trial >= {1'b0, ud_reg});
    assign rem_next = ge ? 32'(trial - {1'b0, ud_reg}) : trial[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            zero_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            zero_reg <= (den == 32'sd0);
            busy_reg <= (den != 32'sd0) && !start_ovf;
            cnt_reg  <= CNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            else
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[31] ^ den[31];
            ud_reg  <= den_abs;
            rem_reg <= high_part;
            shf_reg <= dividend[31:0];
            if (den == 32'sd0)
            begin
                quot_reg <= 32'sd0;
            end
            else if (start_ovf)
            begin
                quot_reg <= (num[31] ^ den[31]) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                rem_reg <= rem_next;
                shf_reg <= {shf_reg[30:0], ge};
            end
            else if (shf_reg[31])
            begin
                quot_reg <= neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
            else
            begin
                quot_reg <= neg_reg ? signed'(~shf_reg + 32'd1) : signed'(shf_reg);
            end
        end
    end

    assign busy = busy_reg;
    assign zero = zero_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

>>> src/skf_datapath.sv
// Datapath: registers, shared multiplier pipeline, saturating adder and gain divider.
`default_nettype none

module skf_datapath #(
    parameter int FRAC_BITS = skf_pkg::DEFAULT_FRAC_BITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [skf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [31:0]                        cfg_wdata,
    input  wire logic signed [31:0]                 sample,
    input  wire skf_pkg::skf_cmd_t                  cmd,
    output skf_pkg::skf_status_t                    status,
    output logic signed [31:0]                      estimate,
    output logic                                    gain_div_zero
);
    import skf_pkg::*;

    localparam logic signed [31:0] ONE      = 32'(64'd1 << FRAC_BITS);
    localparam logic signed [31:0] COV_INIT = 32'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [30:0]        Q_INIT   = 31'(64'd2 << FRAC_BITS);
    localparam logic [30:0]        R_INIT   = 31'(64'd4 << FRAC_BITS);
    localparam logic signed [63:0] RND      = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] MAX32    = 64'sd2147483647;
    localparam logic signed [63:0] MIN32    = -64'sd2147483648;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -34'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // configuration
    logic [30:0]        q_reg;
    logic [30:0]        r_reg;
    logic signed [31:0] f_reg;
    logic signed [31:0] h_reg;

    // filter state
    logic signed [31:0] s_reg;
    logic signed [31:0] c_reg;

    // intermediates
    logic signed [31:0] v_reg;
    logic signed [31:0] x0_reg;
    logic signed [31:0] fc_reg;
    logic signed [31:0] p0_reg;
    logic signed [31:0] hp_reg;
    logic signed [31:0] den_reg;
    logic signed [31:0] innov_reg;
    logic signed [31:0] omk_reg;

    // multiplier pipeline
    logic               v1_reg;
    logic               v2_reg;
    skf_op_t            op1_reg;
    skf_op_t            op2_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] mres_reg;

    logic signed [31:0] est_out_reg;
    logic               flag_out_reg;

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod_next;
    logic signed [63:0] rnd_sum;
    logic signed [63:0] rnd_shift;
    logic signed [31:0] mres_next;
    logic signed [33:0] add_base;
    logic               add_sub;
    logic signed [33:0] add_sum;
    logic signed [31:0] add_sat;

    logic               div_busy;
    logic               div_zero;
    logic signed [31:0] k_val;

    skf_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (hp_reg),
        .den   (den_reg),
        .busy  (div_busy),
        .zero  (div_zero),
        .quot  (k_val)
    );

    always_comb
    begin
        case (cmd.op)
            OP_X0:
            begin
                mul_a = f_reg;
                mul_b = s_reg;
            end
            OP_FC:
            begin
                mul_a = f_reg;
                mul_b = c_reg;
            end
            OP_P0:
            begin
                mul_a = fc_reg;
                mul_b = f_reg;
            end
            OP_HP:
            begin
                mul_a = h_reg;
                mul_b = p0_reg;
            end
            OP_DEN:
            begin
                mul_a = hp_reg;
                mul_b = h_reg;
            end
            OP_INN:
            begin
                mul_a = h_reg;
                mul_b = x0_reg;
            end
            OP_EST:
            begin
                mul_a = k_val;
                mul_b = innov_reg;
            end
            OP_KH:
            begin
                mul_a = k_val;
                mul_b = h_reg;
            end
            OP_COV:
            begin
                mul_a = omk_reg;
                mul_b = p0_reg;
            end
            default:
            begin
                mul_a = f_reg;
                mul_b = s_reg;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // round half up, then saturate
    assign rnd_sum   = prod_reg + RND;
    assign rnd_shift = rnd_sum >>> FRAC_BITS;
    assign mres_next = (rnd_shift > MAX32) ? 32'sh7FFF_FFFF :
                       (rnd_shift < MIN32) ? 32'sh8000_0000 : rnd_shift[31:0];

    always_comb
    begin
        case (op2_reg)
            OP_P0:
            begin
                add_base = signed'({3'b000, q_reg});
                add_sub  = 1'b0;
            end
            OP_DEN:
            begin
                add_base = signed'({3'b000, r_reg});
                add_sub  = 1'b0;
            end
            OP_INN:
            begin
                add_base = 34'(v_reg);
                add_sub  = 1'b1;
            end
            OP_EST:
            begin
                add_base = 34'(x0_reg);
                add_sub  = 1'b0;
            end
            OP_KH:
            begin
                add_base = 34'(ONE);
                add_sub  = 1'b1;
            end
            default:
            begin
                add_base = 34'sd0;
                add_sub  = 1'b0;
            end
        endcase
    end

    assign add_sum = add_sub ? (add_base - 34'(mres_reg)) : (add_base + 34'(mres_reg));
    assign add_sat = sat34(add_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg  <= Q_INIT;
            r_reg  <= R_INIT;
            f_reg  <= ONE;
            h_reg  <= ONE;
            s_reg  <= 32'sd0;
            c_reg  <= COV_INIT;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_PROCESS_NOISE:     q_reg <= cfg_wdata[30:0];
                    REG_MEASUREMENT_NOISE: r_reg <= cfg_wdata[30:0];
                    REG_STATE_GAIN:        f_reg <= signed'(cfg_wdata);
                    REG_OBSERVE_GAIN:      h_reg <= signed'(cfg_wdata);
                    default:               ;
                endcase
            end

            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;

            if (cmd.init_load)
            begin
                s_reg <= v_reg;
                c_reg <= COV_INIT;
            end
            else if (v2_reg && (op2_reg == OP_EST))
            begin
                s_reg <= add_sat;
            end
            else if (v2_reg && (op2_reg == OP_COV))
            begin
                c_reg <= mres_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            v_reg <= sample;
        end
        if (cmd.issue)
        begin
            prod_reg <= prod_next;
            op1_reg  <= cmd.op;
        end
        if (v1_reg)
        begin
            mres_reg <= mres_next;
            op2_reg  <= op1_reg;
        end
        if (v2_reg)
        begin
            case (op2_reg)
                OP_X0:   x0_reg    <= mres_reg;
                OP_FC:   fc_reg    <= mres_reg;
                OP_P0:   p0_reg    <= add_sat;
                OP_HP:   hp_reg    <= mres_reg;
                OP_DEN:  den_reg   <= add_sat;
                OP_INN:  innov_reg <= add_sat;
                OP_KH:   omk_reg   <= add_sat;
                default: ;
            endcase
        end
        if (cmd.out_load)
        begin
            est_out_reg  <= s_reg;
            flag_out_reg <= cmd.out_flag & div_zero;
        end
    end

    assign status.mul_busy = v1_reg;
    assign status.div_busy = div_busy;
    assign estimate        = est_out_reg;
    assign gain_div_zero   = flag_out_reg;

endmodule

`default_nettype wire

>>> src/skf_ctrl.sv
// Controller: sequences the predict and correct steps and runs both stream handshakes.
`default_nettype none

module skf_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire skf_pkg::skf_status_t status,
    output skf_pkg::skf_cmd_t         cmd
);
    import skf_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_INIT = 4'd1;
    localparam logic [3:0] ST_X0   = 4'd2;
    localparam logic [3:0] ST_FC   = 4'd3;
    localparam logic [3:0] ST_P0   = 4'd4;
    localparam logic [3:0] ST_HP   = 4'd5;
    localparam logic [3:0] ST_DEN  = 4'd6;
    localparam logic [3:0] ST_DIV  = 4'd7;
    localparam logic [3:0] ST_EST  = 4'd8;
    localparam logic [3:0] ST_KH   = 4'd9;
    localparam logic [3:0] ST_COV  = 4'd10;
    localparam logic [3:0] ST_DONE = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       issued_reg;
    logic       issued_next;
    logic       kind_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic [3:0] step_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        case (state_reg)
            ST_X0:   step_next = ST_FC;
            ST_FC:   step_next = ST_P0;
            ST_P0:   step_next = ST_HP;
            ST_HP:   step_next = ST_DEN;
            ST_DEN:  step_next = ST_DIV;
            ST_DIV:  step_next = ST_EST;
            ST_EST:  step_next = ST_KH;
            ST_KH:   step_next = ST_COV;
            default: step_next = ST_DONE;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        issued_next   = issued_reg;
        cmd.in_load   = 1'b0;
        cmd.init_load = 1'b0;
        cmd.issue     = 1'b0;
        cmd.div_start = 1'b0;
        cmd.out_load  = 1'b0;
        cmd.out_flag  = !kind_reg;

        case (state_reg)
            ST_X0:   cmd.op = OP_X0;
            ST_FC:   cmd.op = OP_FC;
            ST_P0:   cmd.op = OP_P0;
            ST_HP:   cmd.op = OP_HP;
            ST_DEN:  cmd.op = OP_DEN;
            ST_DIV:  cmd.op = OP_INN;
            ST_EST:  cmd.op = OP_EST;
            ST_KH:   cmd.op = OP_KH;
            ST_COV:  cmd.op = OP_COV;
            default: cmd.op = OP_X0;
        endcase

        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_load = accept;
                if (accept)
                begin
                    state_next = s_tuser ? ST_INIT : ST_X0;
                end
            end
            ST_INIT:
            begin
                cmd.init_load = 1'b1;
                state_next    = ST_DONE;
            end
            ST_X0, ST_FC, ST_P0, ST_HP, ST_DEN, ST_EST, ST_KH, ST_COV:
            begin
                cmd.issue = !issued_reg;
                if (issued_reg && !status.mul_busy)
                begin
                    state_next  = step_next;
                    issued_next = 1'b0;
                end
                else
                begin
                    issued_next = 1'b1;
                end
            end
            ST_DIV:
            begin
                // innovation multiply runs alongside the gain division
                cmd.issue     = !issued_reg;
                cmd.div_start = !issued_reg;
                if (issued_reg && !status.mul_busy && !status.div_busy)
                begin
                    state_next  = step_next;
                    issued_next = 1'b0;
                end
                else
                begin
                    issued_next = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next  = ST_IDLE;
                issued_next = 1'b0;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            kind_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                kind_reg <= s_tuser;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/scalar_kalman_filter_core.sv
// Top level of the scalar Kalman filter core: controller plus datapath.
// Usage:
//   Input stream s_*: tdata carries the sample (signed fixed point), tuser the
//   kind (0 = measurement, 1 = load the estimate from the sample).
//   Output stream m_*: one beat per input beat, tdata the new estimate,
//   tuser set when the gain denominator was zero and the gain forced to 0.
//   Configuration: cfg_we/cfg_addr/cfg_wdata write Q, R, F, H (index 0..3);
//   write only while the core is idle.
// Timing:
//   One item at a time; s_tready is high only when the core is idle.
//   Init beat: the sample is loaded in the INIT state and the result in the DONE state.
//   Measurement beat: eight steps on the shared 32x32 multiplier plus a divide
//   step (32 radix-2 quotient bits); the divide step ends early when the gain
//   denominator is zero or the quotient overflows.
//   Results sit in an output register, so the next input beat is taken while
//   the previous result waits; a stalled receiver holds the core in its final
//   step once a second result is ready.
// Reset: asynchronous, active low; estimate 0, covariance 0.1, Q=2, R=4, F=H=1.
`default_nettype none

module scalar_kalman_filter_core #(
    parameter int FRAC_BITS = skf_pkg::DEFAULT_FRAC_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [skf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [31:0]                    cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [31:0]                    s_tdata,   // [31:0] sample
    input  wire logic                           s_tuser,   // [0] kind
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [31:0]                         m_tdata,   // [31:0] estimate
    output logic                                m_tuser    // [0] gain_div_zero
);
    import skf_pkg::*;

    skf_cmd_t           cmd;
    skf_status_t        status;
    logic signed [31:0] estimate;

    skf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    skf_datapath #(
        .FRAC_BITS(FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .sample        (signed'(s_tdata)),
        .cmd           (cmd),
        .status        (status),
        .estimate      (estimate),
        .gain_div_zero (m_tuser)
    );

    assign m_tdata = unsigned'(estimate);

endmodule

`default_nettype wire

>>> src/skf_checker.sv
// Port-level checker for the scalar Kalman filter core, bound to the top level.
`default_nettype none
`include "scalar_kalman_filter_core_macros.svh"

module skf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    `SKF_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `SKF_ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    `SKF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `SKF_ASSERT_SAME(a_result_after_work, clk, rst_n, $rose(m_tvalid), !$past(s_tready))

endmodule

bind scalar_kalman_filter_core skf_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> verif/tb_scalar_kalman_filter_core.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the scalar Kalman filter core.
module tb_scalar_kalman_filter_core;
    import skf_pkg::*;

    localparam int     FRAC          = DEFAULT_FRAC_BITS;
    localparam longint ONE           = longint'(1) <<< FRAC;
    localparam longint COV_INIT      = (ONE + 5) / 10;
    localparam longint S32_HI        = 2147483647;
    localparam longint S32_LO        = -S32_HI - 1;
    localparam logic   KIND_MEASURE  = 1'b0;
    localparam logic   KIND_INIT     = 1'b1;
    localparam int     RAND_PHASES   = 8;
    localparam int     PHASE_BEATS   = 200;
    localparam int     HOLD_PHASE    = 4;
    localparam int     LONG_HOLD     = 400;
    localparam int     DRAIN_CYCLES  = 64;

    typedef struct packed {
        logic        kind;
        logic [31:0] sample;
    } kf_item_t;

    typedef struct packed {
        logic [31:0] estimate;
        logic        div_zero;
    } kf_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    skf_reg_idx_t cfg_addr = REG_PROCESS_NOISE;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;   // [31:0] sample
    logic         s_tuser = 1'b0; // [0] kind
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;        // [31:0] estimate
    logic         m_tuser;        // [0] gain_div_zero

    kf_item_t   pending_items[$];
    kf_result_t expected_estimates[$];
    kf_result_t head_estimate;

    // filter model: configuration and state
    longint q_noise = 2 * ONE;
    longint r_noise = 4 * ONE;
    longint f_gain  = ONE;
    longint h_gain  = ONE;
    longint est_s   = 0;
    longint est_c   = COV_INIT;
    longint trend   = 0;

    bit send_idle_en = 1'b1;
    bit recv_idle_en = 1'b1;
    int gap_left     = 0;
    int hold_left    = 0;
    int long_asked   = 0;
    int long_done    = 0;
    int n_init       = 0;
    int n_meas       = 0;
    int n_zero_gain  = 0;
    int n_checked    = 0;
    int n_settings   = 0;
    int n_errors     = 0;

    always #5 clk = ~clk;

    scalar_kalman_filter_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    function automatic longint clamp32(longint v);
        if (v > S32_HI)
            return S32_HI;
        if (v < S32_LO)
            return S32_LO;
        return v;
    endfunction

    // fixed-point product, rounded half up, saturated
    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b + (longint'(1) <<< (FRAC - 1));
        return clamp32(p >>> FRAC);
    endfunction

    // fixed-point quotient, truncated toward zero, saturated
    function automatic longint qdiv(longint num, longint den);
        longint un;
        longint ud;
        longint q;
        un = (num < 0 ? -num : num) <<< FRAC;
        ud = den < 0 ? -den : den;
        q = un / ud;
        if (q > S32_HI + 1)
            q = S32_HI + 1;
        return ((num < 0) != (den < 0)) ? clamp32(-q) : clamp32(q);
    endfunction

    function automatic kf_result_t kalman_step(logic kind, logic [31:0] sample);
        longint     v;
        longint     x0;
        longint     p0;
        longint     hp;
        longint     den;
        longint     k;
        longint     innov;
        longint     omk;
        kf_result_t res;
        v = longint'(signed'(sample));
        res.div_zero = 1'b0;
        if (kind == KIND_INIT)
        begin
            n_init++;
            est_s = v;
            est_c = COV_INIT;
        end
        else
        begin
            n_meas++;
            x0 = qmul(f_gain, est_s);
            p0 = clamp32(qmul(qmul(f_gain, est_c), f_gain) + q_noise);
            hp = qmul(h_gain, p0);
            den = clamp32(qmul(hp, h_gain) + r_noise);
            if (den == 0)
            begin
                k = 0;
                res.div_zero = 1'b1;
                n_zero_gain++;
            end
            else
                k = qdiv(hp, den);
            innov = clamp32(v - qmul(h_gain, x0));
            est_s = clamp32(x0 + qmul(k, innov));
            omk = clamp32(ONE - qmul(k, h_gain));
            est_c = qmul(omk, p0);
        end
        res.estimate = est_s[31:0];
        return res;
    endfunction

    function automatic logic [31:0] extreme_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            default: return 32'h0001_0000;
        endcase
    endfunction

    // drifting sensor reading with noise, plus raw and extreme words
    function automatic logic [31:0] draw_sample();
        int unsigned pick;
        longint      v;
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            trend = trend + longint'($urandom_range(0, 4 * ONE)) - 2 * ONE;
            if (trend > 1000 * ONE || trend < -1000 * ONE)
                trend = 0;
            v = clamp32(trend + longint'($urandom_range(0, 16 * ONE)) - 8 * ONE);
            return v[31:0];
        end
        if (pick < 94)
            return $urandom();
        return extreme_word();
    endfunction

    function automatic logic [31:0] draw_noise(bit tame);
        int unsigned pick;
        pick = tame ? 9 : $urandom_range(0, 9);
        if (pick < 2)
            return $urandom();
        if (pick < 4)
            return extreme_word();
        return $urandom_range(ONE / 100, 16 * ONE);
    endfunction

    function automatic logic [31:0] draw_gain(bit tame);
        int unsigned pick;
        logic [31:0] g;
        pick = tame ? 9 : $urandom_range(0, 9);
        if (pick < 2)
            return $urandom();
        if (pick < 4)
            return extreme_word();
        g = $urandom_range(ONE / 2, 3 * ONE / 2);
        if ($urandom_range(0, 5) == 0)
            g = -g;
        return g;
    endfunction

    function automatic void queue_item(logic kind, logic [31:0] sample);
        kf_item_t it;
        it.kind = kind;
        it.sample = sample;
        pending_items = {pending_items, it};
    endfunction

    task automatic put_reg(skf_reg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_PROCESS_NOISE:     q_noise = longint'(val[30:0]);
            REG_MEASUREMENT_NOISE: r_noise = longint'(val[30:0]);
            REG_STATE_GAIN:        f_gain  = longint'(signed'(val));
            REG_OBSERVE_GAIN:      h_gain  = longint'(signed'(val));
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [31:0] q, logic [31:0] r, logic [31:0] f,
                                  logic [31:0] h);
        put_reg(REG_PROCESS_NOISE, q);
        put_reg(REG_MEASUREMENT_NOISE, r);
        put_reg(REG_STATE_GAIN, f);
        put_reg(REG_OBSERVE_GAIN, h);
        @(posedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // block until the core is idle with every result delivered
    task automatic settle();
        while (pending_items.size() != 0 || expected_estimates.size() != 0 || s_tvalid
               || !s_tready)
            @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= KIND_MEASURE;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_estimates = {expected_estimates, kalman_step(s_tuser, s_tdata)};
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() == 0)
                    s_tvalid <= 1'b0;
                else if (send_idle_en && $urandom_range(0, 3) == 0)
                begin
                    gap_left = $urandom_range(0, 16);
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_items[0].sample;
                    s_tuser  <= pending_items[0].kind;
                    pending_items.delete(0);
                end
            end
        end
    end

    // monitor and result checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_estimates.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: unexpected result beat, expected none, actual %h/%b",
                             $time, m_tdata, m_tuser);
                end
                else
                begin
                    head_estimate = expected_estimates[0];
                    expected_estimates.delete(0);
                    n_checked++;
                    if (m_tdata !== head_estimate.estimate)
                    begin
                        n_errors++;
                        $display("%0t: estimate mismatch, expected %h actual %h",
                                 $time, head_estimate.estimate, m_tdata);
                    end
                    if (m_tuser !== head_estimate.div_zero)
                    begin
                        n_errors++;
                        $display("%0t: gain_div_zero mismatch, expected %b actual %b",
                                 $time, head_estimate.div_zero, m_tuser);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (long_asked != long_done)
            begin
                long_done++;
                hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end
            else if (recv_idle_en && $urandom_range(0, 15) == 0)
            begin
                hold_left = $urandom_range(0, 16);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        #10_000_000;
        $display("%0t: timeout, %0d results still expected", $time, expected_estimates.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: field extremes, init and measurement
        queue_item(KIND_MEASURE, 32'h0000_0000);
        queue_item(KIND_MEASURE, 32'h7FFF_FFFF);
        queue_item(KIND_MEASURE, 32'h8000_0000);
        queue_item(KIND_MEASURE, 32'hFFFF_FFFF);
        queue_item(KIND_MEASURE, 32'h0000_0001);
        queue_item(KIND_INIT, 32'h7FFF_FFFF);
        queue_item(KIND_MEASURE, 32'h7FFF_FFFF);
        queue_item(KIND_INIT, 32'h8000_0000);
        queue_item(KIND_MEASURE, 32'h8000_0000);
        queue_item(KIND_INIT, 32'h0005_0000);
        queue_item(KIND_MEASURE, 32'h0005_0000);
        queue_item(KIND_MEASURE, 32'h0006_0000);
        settle();

        // zero gain denominator
        apply_settings(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
        queue_item(KIND_MEASURE, 32'h0003_0000);
        queue_item(KIND_MEASURE, 32'h8000_0000);
        queue_item(KIND_INIT, 32'h0001_0000);
        queue_item(KIND_MEASURE, 32'h7FFF_FFFF);
        settle();

        // saturating noise and gains, top bit of the noise words set
        apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_item(KIND_INIT, 32'h0001_0000);
        queue_item(KIND_MEASURE, 32'h7FFF_FFFF);
        queue_item(KIND_MEASURE, 32'h8000_0000);
        queue_item(KIND_MEASURE, 32'h0000_0000);
        settle();

        apply_settings(32'h0000_0001, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_item(KIND_MEASURE, 32'h0001_0000);
        queue_item(KIND_MEASURE, 32'hFFFF_0000);
        queue_item(KIND_MEASURE, 32'h0000_0000);
        settle();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            send_idle_en = (ph != HOLD_PHASE) && (ph != RAND_PHASES - 1);
            recv_idle_en = (ph != RAND_PHASES - 1);
            apply_settings(draw_noise(ph < 3), draw_noise(ph < 3),
                           draw_gain(ph < 3), draw_gain(ph < 3));
            if (ph == HOLD_PHASE)
                long_asked++;
            queue_item(KIND_INIT, draw_sample());
            for (int i = 1; i < PHASE_BEATS; i++)
            begin
                if ($urandom_range(0, 99) < 8)
                    queue_item(KIND_INIT, draw_sample());
                else
                    queue_item(KIND_MEASURE, draw_sample());
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d init and %0d measurement beats, %0d with a zero gain divisor",
                 n_init, n_meas, n_zero_gain);
        $display("%0d results checked over %0d register settings, incl. a %0d-cycle stall",
                 n_checked, n_settings, LONG_HOLD);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
